// ===== src/checked_text_frame_receiver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Checked text frame receiver assertion macros
// Concurrent assertion shorthands clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CHECKED_TEXT_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CHECKED_TEXT_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define CTFR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CTFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ctfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked text frame receiver package
// Request and result payload types, character codes and class flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctfr_pkg;

	localparam logic [7:0] CH_START   = 8'h40; // '@'
	localparam logic [7:0] CH_END     = 8'h24; // '$'
	localparam logic [7:0] CH_HASH    = 8'h23; // '#'
	localparam logic [7:0] CH_COLON   = 8'h3A; // ':'
	localparam logic [7:0] CH_UNDER   = 8'h5F; // '_'
	localparam logic [7:0] CH_DOT     = 8'h2E; // '.'
	localparam logic [7:0] CH_BAR     = 8'h7C; // '|'
	localparam logic [7:0] CH_DASH    = 8'h2D; // '-'
	localparam logic [7:0] CH_DIG_LO  = 8'h30; // '0'
	localparam logic [7:0] CH_DIG_HI  = 8'h39; // '9'
	localparam logic [7:0] CH_UPR_LO  = 8'h41; // 'A'
	localparam logic [7:0] CH_UPR_HI  = 8'h5A; // 'Z'
	localparam logic [7:0] CH_LWR_LO  = 8'h61; // 'a'
	localparam logic [7:0] CH_LWR_HI  = 8'h7A; // 'z'

	localparam int ADDR_W = 7;
	localparam int SUM_W  = 16;

	typedef struct packed {
		logic       is_rx_data;
		logic [7:0] rx_byte;
		logic       ack;
	} req_item_t;

	typedef struct packed {
		logic              store_en;
		logic [ADDR_W-1:0] store_addr;
		logic [6:0]        store_char;
		logic              frame_end;
		logic [ADDR_W-1:0] frame_length;
		logic [SUM_W-1:0]  sum_out;
		logic              complete_flag;
		logic              valid_flag;
	} rsp_item_t;

	typedef struct packed {
		logic is_start;
		logic is_end;
		logic keep;
	} char_class_t;

endpackage

// ===== src/ctfr_char_filter.sv =====
// ----------------------------------------------------------------------------
// Character filter
// Classifies a received byte as frame start, frame end and storable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctfr_char_filter
	import ctfr_pkg::*;
(
	input  logic [7:0]  rx_byte,
	output char_class_t cls
);

	logic is_digit;
	logic is_upper;
	logic is_lower;
	logic is_symbol;

	always_comb begin
		is_digit  = (rx_byte >= CH_DIG_LO) && (rx_byte <= CH_DIG_HI);
		is_upper  = (rx_byte >= CH_UPR_LO) && (rx_byte <= CH_UPR_HI);
		is_lower  = (rx_byte >= CH_LWR_LO) && (rx_byte <= CH_LWR_HI);
		is_symbol = (rx_byte == CH_START) || (rx_byte == CH_END) ||
			(rx_byte == CH_HASH) || (rx_byte == CH_COLON) ||
			(rx_byte == CH_UNDER) || (rx_byte == CH_DOT) ||
			(rx_byte == CH_BAR) || (rx_byte == CH_DASH);
		cls.is_start = (rx_byte == CH_START);
		cls.is_end   = (rx_byte == CH_END);
		cls.keep     = is_digit || is_upper || is_lower || is_symbol;
	end

endmodule

// ===== src/ctfr_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// Frame tracker
// Holds the frame state and computes one result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctfr_frame_tracker
	import ctfr_pkg::*;
#(
	parameter int BUF_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  req_item_t   item,
	input  char_class_t cls,
	output rsp_item_t   result
);

	localparam int POS_W = $clog2(BUF_DEPTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUF_DEPTH - 1);

	logic             in_frame_q;
	logic [POS_W-1:0] write_pos_q;
	logic [SUM_W-1:0] char_sum_q;
	logic             done_q;
	logic             good_q;

	logic             in_frame_d;
	logic [POS_W-1:0] write_pos_d;
	logic [SUM_W-1:0] char_sum_d;
	logic             done_d;
	logic             good_d;
	logic [POS_W-1:0] pos_stored;
	logic [POS_W+ADDR_W-1:0] addr_ext;
	logic [POS_W+ADDR_W-1:0] len_ext;
	logic             room;

	always_comb begin
		in_frame_d  = in_frame_q;
		write_pos_d = write_pos_q;
		char_sum_d  = char_sum_q;
		done_d      = done_q && !item.ack;
		good_d      = good_q && !item.ack;
		pos_stored  = write_pos_q;
		result      = '0;

		if (item.is_rx_data) begin
			if (cls.is_start) begin
				in_frame_d  = 1'b1;
				write_pos_d = '0;
				char_sum_d  = '0;
			end
			pos_stored = write_pos_d;
			room = in_frame_d && (write_pos_d < POS_LAST);
			if (room) begin
				if (cls.keep) begin
					result.store_en   = 1'b1;
					result.store_char = item.rx_byte[6:0];
					write_pos_d       = write_pos_d + 1'b1;
					char_sum_d        = char_sum_d + SUM_W'(item.rx_byte);
				end
				if (cls.is_end) begin
					in_frame_d       = 1'b0;
					result.frame_end = 1'b1;
					done_d = (char_sum_d != '0) && (write_pos_d > POS_W'(1));
					good_d = done_d;
				end
			end
		end else begin
			room = 1'b0;
		end

		addr_ext = {{ADDR_W{1'b0}}, pos_stored};
		len_ext  = {{ADDR_W{1'b0}}, write_pos_d};
		if (result.store_en) begin
			result.store_addr = addr_ext[ADDR_W-1:0];
		end
		if (result.frame_end) begin
			result.frame_length = len_ext[ADDR_W-1:0];
			write_pos_d         = '0;
		end

		// An open frame that already holds data keeps both flags low.
		if (in_frame_d && (write_pos_d != '0)) begin
			done_d = 1'b0;
			good_d = 1'b0;
		end

		result.sum_out       = char_sum_d;
		result.complete_flag = done_d;
		result.valid_flag    = good_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			write_pos_q <= '0;
			char_sum_q  <= '0;
			done_q      <= 1'b0;
			good_q      <= 1'b0;
		end else if (advance) begin
			in_frame_q  <= in_frame_d;
			write_pos_q <= write_pos_d;
			char_sum_q  <= char_sum_d;
			done_q      <= done_d;
			good_q      <= good_d;
		end
	end

endmodule

// ===== src/checked_text_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Checked text frame receiver
// Extracts '@'...'$' text frames from received bytes, with a running sum.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload    | Handshake
// req     | in        | req_item_t | req_valid / req_ready
// rsp     | out       | rsp_item_t | rsp_valid / rsp_ready
//
// Requests pass the input register, results the output register; one request
// per cycle is sustained unless rsp stalls, set by the tracker's single step.
// Reset clears the frame state and both pipeline valid bits.
// A stalled result stays in the output register while the input register
// still takes one more request; req_ready drops only when both are full.
`timescale 1ns / 1ps

module checked_text_frame_receiver_unit
	import ctfr_pkg::*;
#(
	parameter int BUF_DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req_data,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp_data
);

	`include "checked_text_frame_receiver_unit_macros.svh"

	logic        valid_s1;
	req_item_t   item_s1;
	logic        valid_s2;
	rsp_item_t   result_s2;
	logic        advance;
	char_class_t cls;
	rsp_item_t   result;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = valid_s2;
	assign rsp_data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	ctfr_char_filter u_filter (
		.rx_byte (item_s1.rx_byte),
		.cls     (cls)
	);

	ctfr_frame_tracker #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cls     (cls),
		.result  (result)
	);

	`CTFR_ASSERT_IMPL(a_full_stall, valid_s1 && valid_s2 && !rsp_ready, !req_ready,
		"request taken while both stages are full")
	`CTFR_ASSERT_NEXT(a_advance_fills, advance, valid_s2,
		"advanced request left no result")
	`CTFR_ASSERT_IMPL(a_end_stored, valid_s2 && result_s2.frame_end,
		result_s2.store_en && (result_s2.store_char == CH_END[6:0]),
		"frame closed without a stored terminator")
	`CTFR_ASSERT_IMPL(a_flags_agree, valid_s2,
		result_s2.complete_flag == result_s2.valid_flag,
		"complete and valid flags disagree")

endmodule

// ===== dv/checked_text_frame_receiver_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Checked text frame receiver testbench
// Drives received-byte requests through the valid/ready request channel and
// checks each result against a cycle-free model of the frame tracker or a
// typed row's result. A short directed table comes first, then random frames
// with noise, buffer overflow, and random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checked_text_frame_receiver_unit_tb;
	import ctfr_pkg::*;

	localparam int BUF_DEPTH   = 128;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQS = 750;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		req_item_t rq;
		bit        typed;
		rsp_item_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req_data;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp_data;

	// Frame tracker model state.
	bit          fr_open;
	int          fr_pos;
	logic [15:0] fr_sum;
	bit          fr_done;
	bit          fr_good;

	rsp_item_t frame_rsp_q[$];
	dir_row_t  dir_tab[$];
	int        fail_cnt;
	int        sent_cnt;
	int        cycle_cnt;
	bit        hold_off_now;
	bit        calm;

	checked_text_frame_receiver_unit #(
		.BUF_DEPTH(BUF_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic bit is_kept_char(input logic [7:0] c);
		return (c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UPR_LO && c <= CH_UPR_HI) ||
			(c >= CH_LWR_LO && c <= CH_LWR_HI) || c == CH_START || c == CH_END ||
			c == CH_HASH || c == CH_COLON || c == CH_UNDER || c == CH_DOT ||
			c == CH_BAR || c == CH_DASH;
	endfunction

	function automatic rsp_item_t track_frame(input req_item_t rq);
		rsp_item_t r;
		logic [7:0] c;
		r = '0;
		c = rq.rx_byte;
		if (rq.ack) begin
			fr_done = 1'b0;
			fr_good = 1'b0;
		end
		if (rq.is_rx_data) begin
			if (c == CH_START) begin
				fr_open = 1'b1;
				fr_pos  = 0;
				fr_sum  = '0;
			end
			if (fr_open && fr_pos < BUF_DEPTH - 1) begin
				if (is_kept_char(c)) begin
					r.store_en   = 1'b1;
					r.store_addr = ADDR_W'(fr_pos);
					r.store_char = c[6:0];
					fr_pos++;
					fr_sum = fr_sum + 16'(c);
				end
				if (c == CH_END) begin
					fr_open        = 1'b0;
					r.frame_end    = 1'b1;
					r.frame_length = ADDR_W'(fr_pos);
					fr_done        = (fr_sum != 0 && fr_pos > 1);
					fr_good        = fr_done;
					fr_pos         = 0;
				end
			end
		end
		// An open frame holding data keeps both flags down.
		if (fr_open && fr_pos > 0) begin
			fr_done = 1'b0;
			fr_good = 1'b0;
		end
		r.sum_out       = fr_sum;
		r.complete_flag = fr_done;
		r.valid_flag    = fr_good;
		return r;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_text_char();
		logic [7:0] sym [6];
		sym = '{CH_HASH, CH_COLON, CH_UNDER, CH_DOT, CH_BAR, CH_DASH};
		case ($urandom_range(0, 3))
			0: return 8'(CH_DIG_LO + $urandom_range(0, 9));
			1: return 8'(CH_UPR_LO + $urandom_range(0, 25));
			2: return 8'(CH_LWR_LO + $urandom_range(0, 25));
			default: return sym[$urandom_range(0, 5)];
		endcase
	endfunction

	task automatic send_req(input req_item_t rq, input bit typed, input rsp_item_t want);
		rsp_item_t pred;
		int gap;
		req_valid <= 1'b1;
		req_data  <= rq;
		do @(posedge clk); while (!req_ready);
		pred = track_frame(rq);
		frame_rsp_q.push_back(typed ? want : pred);
		sent_cnt++;
		gap = gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input bit rx, input logic [7:0] b, input bit ack);
		req_item_t rq;
		rq.is_rx_data = rx;
		rq.rx_byte    = b;
		rq.ack        = ack;
		send_req(rq, 1'b0, '0);
	endtask

	task automatic add_row(input bit rx, input logic [7:0] b, input bit ack,
			input bit typed, input rsp_item_t want);
		dir_row_t row;
		row.rq.is_rx_data = rx;
		row.rq.rx_byte    = b;
		row.rq.ack        = ack;
		row.typed         = typed;
		row.want          = want;
		dir_tab.push_back(row);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (frame_rsp_q.size() != 0);
	endtask

	// Result checker.
	always @(posedge clk) begin
		rsp_item_t exp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (frame_rsp_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected result: %h", rsp_data);
			end else begin
				exp = frame_rsp_q.pop_front();
				if (rsp_data.store_en !== exp.store_en ||
						rsp_data.store_addr !== exp.store_addr ||
						rsp_data.store_char !== exp.store_char ||
						rsp_data.frame_end !== exp.frame_end ||
						rsp_data.frame_length !== exp.frame_length ||
						rsp_data.sum_out !== exp.sum_out ||
						rsp_data.complete_flag !== exp.complete_flag ||
						rsp_data.valid_flag !== exp.valid_flag) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("mismatch: exp en=%0d addr=%0d chr=%h end=%0d len=%0d sum=%h cmp=%0d val=%0d",
							exp.store_en, exp.store_addr, exp.store_char, exp.frame_end,
							exp.frame_length, exp.sum_out, exp.complete_flag, exp.valid_flag);
						$display("          got en=%0d addr=%0d chr=%h end=%0d len=%0d sum=%h cmp=%0d val=%0d",
							rsp_data.store_en, rsp_data.store_addr, rsp_data.store_char,
							rsp_data.frame_end, rsp_data.frame_length, rsp_data.sum_out,
							rsp_data.complete_flag, rsp_data.valid_flag);
					end
				end
			end
		end
	end

	// Result side: random ready pattern, plus one long hold-off on request.
	initial begin
		int run;
		int gap;
		rsp_ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_now) begin
				hold_off_now = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			run = $urandom_range(1, 24);
			rsp_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = gap_len();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		int  len;
		int  n;
		int  r;
		int  frames;
		bit  held;
		bit  paused;
		bit  ack;
		req_valid = 1'b0;
		req_data  = '0;
		arst_n    = 1'b0;
		fail_cnt  = 0;
		sent_cnt  = 0;
		cycle_cnt = 0;
		hold_off_now = 1'b0;
		calm      = 1'b0;
		frames    = 0;
		held      = 1'b0;
		paused    = 1'b0;

		// Directed table; typed rows hold results that are plain to see.
		add_row(1'b0, 8'hFF, 1'b0, 1'b1, '0);
		add_row(1'b1, CH_UPR_LO, 1'b0, 1'b1, '0);
		add_row(1'b1, CH_END, 1'b1, 1'b1, '0);
		add_row(1'b1, CH_START, 1'b0, 1'b1,
			'{1'b1, 7'd0, 7'h40, 1'b0, 7'd0, 16'h0040, 1'b0, 1'b0});
		add_row(1'b1, CH_END, 1'b0, 1'b1,
			'{1'b1, 7'd1, 7'h24, 1'b1, 7'd2, 16'h0064, 1'b1, 1'b1});
		add_row(1'b0, CH_START, 1'b0, 1'b1,
			'{1'b0, 7'd0, 7'h00, 1'b0, 7'd0, 16'h0064, 1'b1, 1'b1});
		add_row(1'b0, 8'h00, 1'b1, 1'b1,
			'{1'b0, 7'd0, 7'h00, 1'b0, 7'd0, 16'h0064, 1'b0, 1'b0});
		add_row(1'b1, CH_START, 1'b1, 1'b0, '0);
		add_row(1'b1, CH_UPR_HI, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_DIG_LO, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_DIG_HI, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_LWR_LO, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_LWR_HI, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_HASH, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_COLON, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_UNDER, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_DOT, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_BAR, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_DASH, 1'b0, 1'b0, '0);
		add_row(1'b1, 8'hFF, 1'b0, 1'b0, '0);
		add_row(1'b1, 8'h00, 1'b1, 1'b0, '0);
		add_row(1'b1, 8'hC1, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_START, 1'b0, 1'b0, '0);
		add_row(1'b1, 8'h42, 1'b0, 1'b0, '0);
		add_row(1'b1, CH_END, 1'b0, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
		drain_results();

		// Random frames with noise; a few frames overrun the buffer.
		while (sent_cnt < dir_tab.size() + RANDOM_REQS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < 20) begin
				n = $urandom_range(1, 6);
				repeat (n)
					send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 9) == 0);
			end else begin
				if (frames == 2 || frames == 30 || $urandom_range(0, 99) < 2)
					len = $urandom_range(124, 140);
				else
					len = $urandom_range(0, 16);
				send_byte(1'b1, CH_START, $urandom_range(0, 19) == 0);
				for (int k = 0; k < len; k++) begin
					r   = $urandom_range(0, 99);
					ack = ($urandom_range(0, 19) == 0);
					if (r < 82)
						send_byte(1'b1, pick_text_char(), ack);
					else if (r < 92)
						send_byte(1'b1, 8'($urandom_range(0, 255)), ack);
					else
						send_byte(1'b0, 8'($urandom_range(0, 255)), ack);
				end
				if ($urandom_range(0, 99) < 88)
					send_byte(1'b1, CH_END, $urandom_range(0, 19) == 0);
				frames++;
			end
			// The result side stalls for a long stretch while requests keep coming.
			if (!held && sent_cnt > 250) begin
				held = 1'b1;
				hold_off_now = 1'b1;
			end
			if (!paused && sent_cnt > 500) begin
				paused = 1'b1;
				drain_results();
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && frame_rsp_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
